@@ sv/nrpc_pkg.sv @@
// nrpc_pkg: shared types and constants for the napot region permission check unit
// no dependencies; imported by the interfaces, controller, datapath and top level
package nrpc_pkg;

  localparam int SLOT_FIELD_W = 5;
  localparam int ADDR_FIELD_W = 64;
  localparam int ORDER_W      = 7;
  localparam int PERM_W       = 3;
  localparam int PRIV_W       = 2;

  localparam logic        KIND_WRITE   = 1'b0;
  localparam logic        KIND_CHECK   = 1'b1;
  localparam logic [1:0]  MACHINE_MODE = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic write;    // load one table entry from the request
    logic start;    // capture check request, read slot 0
    logic advance;  // read next slot
    logic finish;   // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // current slot hits, ends the list, or is the last one
  } status_t;

endpackage

@@ sv/nrpc_req_if.sv @@
// nrpc_req_if: request channel of the napot region permission check unit
// depends on nrpc_pkg for field widths
interface nrpc_req_if;
  import nrpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [SLOT_FIELD_W-1:0] entry_slot;
  logic [ADDR_FIELD_W-1:0] entry_base;
  logic [ORDER_W-1:0]      entry_order;
  logic [PERM_W-1:0]       entry_machine_perm;
  logic [PERM_W-1:0]       entry_lower_perm;
  logic                    entry_is_device;
  logic [ADDR_FIELD_W-1:0] check_address;
  logic [PRIV_W-1:0]       privilege;
  logic [PERM_W-1:0]       wanted_perm;
  logic                    wanted_device;

  modport source (
    output valid, kind, entry_slot, entry_base, entry_order, entry_machine_perm,
           entry_lower_perm, entry_is_device, check_address, privilege, wanted_perm,
           wanted_device,
    input  ready
  );

  modport sink (
    input  valid, kind, entry_slot, entry_base, entry_order, entry_machine_perm,
           entry_lower_perm, entry_is_device, check_address, privilege, wanted_perm,
           wanted_device,
    output ready
  );

endinterface

@@ sv/nrpc_rsp_if.sv @@
// nrpc_rsp_if: result channel of the napot region permission check unit
// depends on nrpc_pkg for field widths
interface nrpc_rsp_if;
  import nrpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    allowed;
  logic                    region_hit;
  logic [SLOT_FIELD_W-1:0] hit_slot;

  modport source (
    output valid, allowed, region_hit, hit_slot,
    input  ready
  );

  modport sink (
    input  valid, allowed, region_hit, hit_slot,
    output ready
  );

endinterface

@@ sv/nrpc_ctrl.sv @@
// nrpc_ctrl: request/scan sequencer and result valid register
// depends on nrpc_pkg (state_e, cmd_t, status_t, request kinds)
module nrpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_kind_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  nrpc_pkg::status_t status_i,
  output nrpc_pkg::cmd_t    cmd_o
);
  import nrpc_pkg::*;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_kind_i == KIND_CHECK) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          // hold the finished scan until the result register is free
          if (!rsp_valid_q || rsp_ready_i) begin
            cmd_o.finish = 1'b1;
            rsp_valid_d  = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

@@ sv/nrpc_datapath.sv @@
// nrpc_datapath: region table memory, scan pointer, range compare and result register
// depends on nrpc_pkg (cmd_t, status_t, field widths, mode codes)
module nrpc_datapath #(
  parameter int REGION_SLOTS = 32,
  parameter int ADDR_BITS    = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  nrpc_pkg::cmd_t                      cmd_i,
  output nrpc_pkg::status_t                   status_o,
  input  logic [nrpc_pkg::SLOT_FIELD_W-1:0]   entry_slot_i,
  input  logic [nrpc_pkg::ADDR_FIELD_W-1:0]   entry_base_i,
  input  logic [nrpc_pkg::ORDER_W-1:0]        entry_order_i,
  input  logic [nrpc_pkg::PERM_W-1:0]         entry_machine_perm_i,
  input  logic [nrpc_pkg::PERM_W-1:0]         entry_lower_perm_i,
  input  logic                                entry_is_device_i,
  input  logic [nrpc_pkg::ADDR_FIELD_W-1:0]   check_address_i,
  input  logic [nrpc_pkg::PRIV_W-1:0]         privilege_i,
  input  logic [nrpc_pkg::PERM_W-1:0]         wanted_perm_i,
  input  logic                                wanted_device_i,
  output logic                                allowed_o,
  output logic                                region_hit_o,
  output logic [nrpc_pkg::SLOT_FIELD_W-1:0]   hit_slot_o
);
  import nrpc_pkg::*;

  localparam int                 SLOT_W      = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam logic [31:0]        SLOTS_L     = 32'(REGION_SLOTS);
  localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(REGION_SLOTS - 1);
  localparam logic [ORDER_W-1:0] ORDER_WHOLE = ORDER_W'(ADDR_BITS);

  // end address is worked out when the entry is written
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] last_addr;
    logic [PERM_W-1:0]    machine_perm;
    logic [PERM_W-1:0]    lower_perm;
    logic                 is_device;
  } entry_t;

  entry_t                  mem [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] live_q;  // slot written with a nonzero order

  entry_t               ent_q;
  logic                 ent_live_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 machine_q;
  logic [PERM_W-1:0]    wanted_q;
  logic                 dev_q;
  logic                 allowed_q;
  logic                 hit_q;
  logic [SLOT_FIELD_W-1:0] slot_q;

  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_idx;
  logic [ADDR_BITS-1:0] wr_base;
  logic [ADDR_BITS-1:0] size_m1;
  logic [ADDR_BITS-1:0] wr_last;
  entry_t               wr_entry;
  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_idx;
  logic                 hit;
  logic [PERM_W-1:0]    have;
  logic                 ok;

  // table write
  assign wr_en   = cmd_i.write && (32'(entry_slot_i) < SLOTS_L);
  assign wr_idx  = SLOT_W'(entry_slot_i);
  assign wr_base = entry_base_i[ADDR_BITS-1:0];
  assign size_m1 = ~({ADDR_BITS{1'b1}} << entry_order_i);
  assign wr_last = (entry_order_i >= ORDER_WHOLE) ? {ADDR_BITS{1'b1}} : wr_base + size_m1;

  always_comb begin
    wr_entry.base         = wr_base;
    wr_entry.last_addr    = wr_last;
    wr_entry.machine_perm = entry_machine_perm_i;
    wr_entry.lower_perm   = entry_lower_perm_i;
    wr_entry.is_device    = entry_is_device_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (wr_en) begin
      live_q[wr_idx] <= (entry_order_i != '0);
    end
  end

  // table read, one slot per cycle
  assign rd_en  = cmd_i.start || cmd_i.advance;
  assign rd_idx = cmd_i.start ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ent_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_live_q <= 1'b0;
      idx_q      <= '0;
    end else if (rd_en) begin
      ent_live_q <= live_q[rd_idx];
      idx_q      <= rd_idx;
    end
  end

  // captured check request
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q    <= check_address_i[ADDR_BITS-1:0];
      machine_q <= (privilege_i == MACHINE_MODE);
      wanted_q  <= wanted_perm_i;
      dev_q     <= wanted_device_i;
    end
  end

  // a wrapped end lies below the base, so the range test fails on its own
  assign hit  = ent_live_q && (ent_q.base <= addr_q) && (addr_q <= ent_q.last_addr);
  assign have = machine_q ? ent_q.machine_perm : ent_q.lower_perm;
  assign ok   = !(ent_q.is_device && !dev_q) && ((have & wanted_q) == wanted_q);

  assign status_o.scan_done = !ent_live_q || hit || (idx_q == LAST_SLOT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (hit) begin
        allowed_q <= ok;
        hit_q     <= 1'b1;
        slot_q    <= SLOT_FIELD_W'(idx_q);
      end else begin
        allowed_q <= machine_q;
        hit_q     <= 1'b0;
        slot_q    <= '0;
      end
    end
  end

  assign allowed_o    = allowed_q;
  assign region_hit_o = hit_q;
  assign hit_slot_o   = slot_q;

endmodule

@@ sv/napot_region_permission_check_unit.sv @@
// napot_region_permission_check_unit: top level, joins sequencer and datapath to the channels
// depends on nrpc_pkg, nrpc_req_if, nrpc_rsp_if, nrpc_ctrl, nrpc_datapath
//
// Keeps a table of REGION_SLOTS power-of-two regions and checks accesses against it. A write
// request loads the addressed slot and gives no result. A check request reads the table one slot
// per cycle through its single read port, starting at slot 0 and stopping at the first hit, at
// the first slot of order 0, or at the last slot, so it reads 1 to REGION_SLOTS slots. The
// result register is loaded when the scan ends, and the next request is taken once the block
// is back in idle. The block takes one request at a time; the result register holds the last
// answer until it is taken while the next request is already accepted, and a finished scan
// waits while that answer is still not taken. After reset the table reads as empty at once; no
// clearing pass is needed.
module napot_region_permission_check_unit #(
  parameter int REGION_SLOTS = 32,
  parameter int ADDR_BITS    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nrpc_req_if.sink          req_i,
  nrpc_rsp_if.source        rsp_o
);
  import nrpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  nrpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nrpc_datapath #(
    .REGION_SLOTS (REGION_SLOTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .entry_slot_i         (req_i.entry_slot),
    .entry_base_i         (req_i.entry_base),
    .entry_order_i        (req_i.entry_order),
    .entry_machine_perm_i (req_i.entry_machine_perm),
    .entry_lower_perm_i   (req_i.entry_lower_perm),
    .entry_is_device_i    (req_i.entry_is_device),
    .check_address_i      (req_i.check_address),
    .privilege_i          (req_i.privilege),
    .wanted_perm_i        (req_i.wanted_perm),
    .wanted_device_i      (req_i.wanted_device),
    .allowed_o            (rsp_o.allowed),
    .region_hit_o         (rsp_o.region_hit),
    .hit_slot_o           (rsp_o.hit_slot)
  );

endmodule

@@ dv/napot_region_permission_check_unit_test.sv @@
`timescale 1ns / 1ps
// napot_region_permission_check_unit_test: self-checking bench for the region permission unit
// depends on nrpc_pkg, nrpc_req_if, nrpc_rsp_if and napot_region_permission_check_unit
module napot_region_permission_check_unit_test;
  import nrpc_pkg::*;

  localparam int SLOTS        = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 50;

  localparam logic [PERM_W-1:0]  PERM_NONE  = 3'b000;
  localparam logic [PERM_W-1:0]  PERM_READ  = 3'b001;
  localparam logic [PERM_W-1:0]  PERM_WRITE = 3'b010;
  localparam logic [PERM_W-1:0]  PERM_EXEC  = 3'b100;
  localparam logic [PERM_W-1:0]  PERM_RWX   = 3'b111;
  localparam logic [PRIV_W-1:0]  PRIV_USER  = 2'd0;
  localparam logic [PRIV_W-1:0]  PRIV_SUPER = 2'd1;
  localparam logic [PRIV_W-1:0]  PRIV_HYPER = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_END   = 7'd0;
  localparam logic [ORDER_W-1:0] ORDER_WHOLE = 7'd64;
  localparam logic [ORDER_W-1:0] ORDER_MAX   = 7'd127;

  typedef struct {
    logic                    kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ADDR_FIELD_W-1:0] base;
    logic [ORDER_W-1:0]      order;
    logic [PERM_W-1:0]       mperm;
    logic [PERM_W-1:0]       lperm;
    logic                    dev;
    logic [ADDR_FIELD_W-1:0] addr;
    logic [PRIV_W-1:0]       priv;
    logic [PERM_W-1:0]       want;
    logic                    wdev;
  } request_t;

  typedef struct packed {
    logic                    allowed;
    logic                    region_hit;
    logic [SLOT_FIELD_W-1:0] hit_slot;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  nrpc_req_if req_if ();
  nrpc_rsp_if rsp_if ();

  napot_region_permission_check_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted region table
  logic [ADDR_FIELD_W-1:0] tbl_base  [SLOTS];
  logic [ORDER_W-1:0]      tbl_order [SLOTS];
  logic [6:0]              tbl_perm  [SLOTS];

  verdict_t verdicts_pending[$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  writes_sent    = 0;
  int  checks_sent    = 0;
  int  hits_seen      = 0;
  int  denials_seen   = 0;
  int  cycle_count    = 0;
  bit  idle_enabled   = 1'b1;
  bit  tail_phase     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d checks still pending", cycle_count,
               verdicts_pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [ADDR_FIELD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // last address of a region; orders of the full width or more reach the top
  function automatic logic [ADDR_FIELD_W-1:0] region_last(logic [ADDR_FIELD_W-1:0] b,
                                                          logic [ORDER_W-1:0] o);
    if (o >= ORDER_WHOLE) return '1;
    return b + ((64'd1 << o) - 64'd1);
  endfunction

  function automatic verdict_t predict_verdict(request_t r);
    verdict_t               v;
    logic [ADDR_FIELD_W-1:0] last;
    logic [PERM_W-1:0]       have;
    v.allowed    = (r.priv == MACHINE_MODE);
    v.region_hit = 1'b0;
    v.hit_slot   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_order[s] == ORDER_END) break;
      last = region_last(tbl_base[s], tbl_order[s]);
      if (tbl_base[s] <= r.addr && r.addr <= last) begin
        have = (r.priv == MACHINE_MODE) ? tbl_perm[s][2:0] : tbl_perm[s][5:3];
        // device region refuses any non-device access
        v.allowed    = (tbl_perm[s][6] && !r.wdev) ? 1'b0 : ((have & r.want) == r.want);
        v.region_hit = 1'b1;
        v.hit_slot   = SLOT_FIELD_W'(s);
        return v;
      end
    end
    return v;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.kind  = 1'($urandom_range(0, 1));
    r.slot  = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
    r.base  = rand64();
    r.order = ORDER_W'($urandom_range(0, 127));
    r.mperm = PERM_W'($urandom_range(0, 7));
    r.lperm = PERM_W'($urandom_range(0, 7));
    r.dev   = 1'($urandom_range(0, 1));
    r.addr  = rand64();
    r.priv  = PRIV_W'($urandom_range(0, 3));
    r.want  = PERM_W'($urandom_range(0, 7));
    r.wdev  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(request_t r);
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req_if.kind               <= r.kind;
    req_if.entry_slot         <= r.slot;
    req_if.entry_base         <= r.base;
    req_if.entry_order        <= r.order;
    req_if.entry_machine_perm <= r.mperm;
    req_if.entry_lower_perm   <= r.lperm;
    req_if.entry_is_device    <= r.dev;
    req_if.check_address      <= r.addr;
    req_if.privilege          <= r.priv;
    req_if.wanted_perm        <= r.want;
    req_if.wanted_device      <= r.wdev;
    req_if.valid              <= 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    items_sent++;
    if (r.kind == KIND_CHECK) begin
      verdicts_pending.push_back(predict_verdict(r));
      checks_sent++;
    end else begin
      if (r.slot < SLOTS) begin
        tbl_base[r.slot]  = r.base;
        tbl_order[r.slot] = r.order;
        tbl_perm[r.slot]  = {r.dev, r.lperm, r.mperm};
      end
      writes_sent++;
    end
  endtask

  task automatic send_write(int slot, logic [ADDR_FIELD_W-1:0] base, logic [ORDER_W-1:0] order,
                            logic [PERM_W-1:0] mperm, logic [PERM_W-1:0] lperm, logic dev);
    request_t r;
    r       = random_request();
    r.kind  = KIND_WRITE;
    r.slot  = SLOT_FIELD_W'(slot);
    r.base  = base;
    r.order = order;
    r.mperm = mperm;
    r.lperm = lperm;
    r.dev   = dev;
    send_request(r);
  endtask

  task automatic send_check(logic [ADDR_FIELD_W-1:0] addr, logic [PRIV_W-1:0] priv,
                            logic [PERM_W-1:0] want, logic wdev);
    request_t r;
    r      = random_request();
    r.kind = KIND_CHECK;
    r.addr = addr;
    r.priv = priv;
    r.want = want;
    r.wdev = wdev;
    send_request(r);
  endtask

  // nested regions around one center, random regions mixed in, then a list end unless all slots are filled
  task automatic load_random_table(output int count);
    logic [ADDR_FIELD_W-1:0] center;
    logic [ADDR_FIELD_W-1:0] base;
    logic [ORDER_W-1:0]      ord;
    bit                      reverse;
    int                      slot;
    count   = ($urandom_range(0, 9) == 0) ? SLOTS : $urandom_range(1, 8);
    center  = rand64();
    reverse = $urandom_range(0, 1);
    for (int k = 0; k < count; k++) begin
      slot = reverse ? count - 1 - k : k;
      case ($urandom_range(0, 19))
        0, 1:    ord = ORDER_WHOLE;
        2:       ord = ORDER_W'($urandom_range(65, 127));
        3, 4, 5, 6, 7, 8, 9: ord = ORDER_W'($urandom_range(1, 12));
        default: ord = ORDER_W'($urandom_range(1, 63));
      endcase
      if (ord >= ORDER_WHOLE)
        base = ($urandom_range(0, 3) == 0) ? rand64() : '0;
      else
        base = (($urandom_range(0, 2) == 0) ? rand64() : center) & ~((64'd1 << ord) - 64'd1);
      send_write(slot, base, ord, PERM_W'($urandom_range(0, 7)), PERM_W'($urandom_range(0, 7)),
                 $urandom_range(0, 3) == 0);
    end
    if (count < SLOTS)
      send_write(count, rand64(), ORDER_END, PERM_W'($urandom_range(0, 7)),
                 PERM_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // addresses at the ends of, just outside and inside the loaded regions, plus random ones
  task automatic send_random_checks(int count, int regions);
    logic [ADDR_FIELD_W-1:0] b;
    logic [ADDR_FIELD_W-1:0] last;
    logic [ADDR_FIELD_W-1:0] a;
    logic [ORDER_W-1:0]      o;
    int                      s;
    for (int k = 0; k < count; k++) begin
      s    = $urandom_range(0, regions - 1);
      b    = tbl_base[s];
      o    = tbl_order[s];
      last = region_last(b, o);
      case ($urandom_range(0, 7))
        0:       a = b;
        1:       a = last;
        2:       a = b - 64'd1;
        3:       a = last + 64'd1;
        4, 5:    a = (o >= ORDER_WHOLE) ? (b | rand64())
                                        : (b | (rand64() & ((64'd1 << o) - 64'd1)));
        default: a = rand64();
      endcase
      send_check(a, PRIV_W'($urandom_range(0, 3)), PERM_W'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_empty_table();
    send_check(64'h0, PRIV_USER, PERM_READ, 1'b0);
    send_check('1, PRIV_SUPER, PERM_NONE, 1'b1);
    send_check(64'h8000_0000_0000_0000, PRIV_HYPER, PERM_RWX, 1'b0);
    send_check('1, MACHINE_MODE, PERM_RWX, 1'b0);
  endtask

  task automatic test_whole_space();
    send_write(0, 64'h0, ORDER_WHOLE, PERM_RWX, PERM_NONE, 1'b0);
    send_write(1, rand64(), ORDER_END, PERM_RWX, PERM_RWX, 1'b1);
    send_check('1, PRIV_SUPER, PERM_NONE, 1'b0);
    send_check(64'h0, MACHINE_MODE, PERM_RWX, 1'b1);
    send_check(64'h1234, PRIV_HYPER, PERM_READ, 1'b0);
  endtask

  task automatic test_device_region();
    send_write(0, 64'h1000, 7'd12, PERM_RWX, PERM_RWX, 1'b1);
    send_write(1, 64'h0, ORDER_MAX, PERM_READ, PERM_WRITE, 1'b0);
    send_write(2, rand64(), ORDER_END, PERM_NONE, PERM_NONE, 1'b0);
    send_check(64'h1000, MACHINE_MODE, PERM_RWX, 1'b0);
    send_check(64'h1fff, PRIV_USER, PERM_RWX, 1'b1);
    send_check(64'h2000, PRIV_USER, PERM_WRITE, 1'b0);
    send_check(64'h2000, MACHINE_MODE, PERM_WRITE, 1'b1);
  endtask

  task automatic test_wrapping_region();
    // first region wraps past the top and holds nothing
    send_write(0, 64'hFFFF_FFFF_FFFF_F000, 7'd16, PERM_RWX, PERM_RWX, 1'b0);
    send_write(1, 64'hFFFF_FFFF_FFFF_0000, 7'd16, PERM_EXEC, PERM_READ, 1'b0);
    send_write(2, rand64(), ORDER_END, PERM_RWX, PERM_RWX, 1'b0);
    send_check('1, PRIV_USER, PERM_READ, 1'b0);
    send_check(64'hFFFF_FFFF_FFFF_F000, MACHINE_MODE, PERM_EXEC, 1'b0);
  endtask

  task automatic test_list_end();
    // slot 2 ends the list, so these entries are never scanned
    send_write(3, 64'h0, ORDER_WHOLE, PERM_RWX, PERM_RWX, 1'b0);
    send_write(SLOTS - 1, 64'h0, ORDER_WHOLE, PERM_RWX, PERM_RWX, 1'b0);
    send_check(64'h0, PRIV_USER, PERM_READ, 1'b0);
    send_check(64'h0, MACHINE_MODE, PERM_RWX, 1'b0);
  endtask

  task automatic test_random_tables();
    int count;
    while (items_sent < RANDOM_ITEMS) begin
      idle_enabled = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 15)) send_request(random_request());
      end else begin
        load_random_table(count);
        send_random_checks($urandom_range(10, 40), count);
      end
    end
  endtask

  task automatic test_steady_stream();
    int count;
    tail_phase   = 1'b1;
    idle_enabled = 1'b0;
    load_random_table(count);
    send_random_checks(TAIL_ITEMS, count);
  endtask

  // result ready: random stall bursts with calm stretches between, always ready in the tail phase
  initial begin : rsp_stall_gen
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (tail_phase || calm_left > 0) begin
        rsp_if.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1: begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
          end
          2: begin
            rsp_if.ready <= 1'b1;
            calm_left = $urandom_range(50, 300);
          end
          default: rsp_if.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : rsp_checker
    verdict_t want_v;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (verdicts_pending.size() == 0) begin
        note_mismatch("unrequested result", 64'd0,
                      64'({rsp_if.allowed, rsp_if.region_hit, rsp_if.hit_slot}));
      end else begin
        want_v = verdicts_pending.pop_front();
        if (want_v.region_hit) hits_seen++;
        if (!want_v.allowed) denials_seen++;
        if (rsp_if.allowed !== want_v.allowed)
          note_mismatch("allowed", 64'(want_v.allowed), 64'(rsp_if.allowed));
        if (rsp_if.region_hit !== want_v.region_hit)
          note_mismatch("region_hit", 64'(want_v.region_hit), 64'(rsp_if.region_hit));
        if (rsp_if.hit_slot !== want_v.hit_slot)
          note_mismatch("hit_slot", 64'(want_v.hit_slot), 64'(rsp_if.hit_slot));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid              <= 1'b0;
    req_if.kind               <= KIND_WRITE;
    req_if.entry_slot         <= '0;
    req_if.entry_base         <= '0;
    req_if.entry_order        <= '0;
    req_if.entry_machine_perm <= '0;
    req_if.entry_lower_perm   <= '0;
    req_if.entry_is_device    <= 1'b0;
    req_if.check_address      <= '0;
    req_if.privilege          <= '0;
    req_if.wanted_perm        <= '0;
    req_if.wanted_device      <= 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_base[i]  = '0;
      tbl_order[i] = ORDER_END;
      tbl_perm[i]  = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_whole_space();
    test_device_region();
    test_wrapping_region();
    test_list_end();
    test_random_tables();
    test_steady_stream();
    req_if.valid <= 1'b0;

    while (verdicts_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (verdicts_pending.size() != 0) begin
      $display("%0d checks never answered", verdicts_pending.size());
      mismatch_count += verdicts_pending.size();
    end

    $display("covered %0d table writes and %0d access checks in %0d cycles",
             writes_sent, checks_sent, cycle_count);
    $display("%0d checks hit a region, %0d were denied, %0d mismatches",
             hits_seen, denials_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ napot_region_permission_check_unit.f @@
sv/nrpc_pkg.sv
sv/nrpc_req_if.sv
sv/nrpc_rsp_if.sv
sv/nrpc_ctrl.sv
sv/nrpc_datapath.sv
sv/napot_region_permission_check_unit.sv
dv/napot_region_permission_check_unit_test.sv
